FILE: design/mrf_pkg.sv
// Shared types, constants and the CRC-16 byte step for the Modbus RTU read request framer.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mrf_pkg;

    localparam int FRAME_LEN = 8;
    localparam int IDX_W     = 3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0]  SLAVE_RESET = 8'h01;
    localparam logic [7:0]  FUNC_RESET  = 8'h04;
    localparam logic [15:0] COUNT_RESET = 16'h0002;

    // configuration register indexes
    localparam logic [1:0] CFG_SLAVE = 2'd0;
    localparam logic [1:0] CFG_FUNC  = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    // frame byte positions
    localparam logic [IDX_W-1:0] BYTE_SLAVE   = 3'd0;
    localparam logic [IDX_W-1:0] BYTE_FUNC    = 3'd1;
    localparam logic [IDX_W-1:0] BYTE_ADDR_HI = 3'd2;
    localparam logic [IDX_W-1:0] BYTE_ADDR_LO = 3'd3;
    localparam logic [IDX_W-1:0] BYTE_CNT_HI  = 3'd4;
    localparam logic [IDX_W-1:0] BYTE_CNT_LO  = 3'd5;
    localparam logic [IDX_W-1:0] BYTE_CRC_LO  = 3'd6;
    localparam logic [IDX_W-1:0] BYTE_CRC_HI  = 3'd7;

    typedef struct packed {
        logic [7:0]  slave;
        logic [7:0]  func;
        logic [15:0] addr;
        logic [15:0] count;
    } request_t;

    // fold one byte into the CRC, LSB first, reflected polynomial
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] acc;
        acc = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (acc[0])
            begin
                acc = (acc >> 1) ^ CRC_POLY;
            end
            else
            begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

FILE: design/mrf_front.sv
// Front end: configuration registers and request capture into the queue.
// Depends on mrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrf_front (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_write,
    input  wire [1:0]              cfg_index,
    input  wire [15:0]             cfg_data,
    input  wire                    push,
    input  wire [15:0]             register_address,
    input  wire                    q_full,
    output logic                   q_push,
    output mrf_pkg::request_t      q_data
);
    import mrf_pkg::*;

    logic [7:0]  slave_reg;
    logic [7:0]  func_reg;
    logic [15:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_reg <= SLAVE_RESET;
            func_reg  <= FUNC_RESET;
            count_reg <= COUNT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SLAVE: slave_reg <= cfg_data[7:0];
                CFG_FUNC:  func_reg  <= cfg_data[7:0];
                CFG_COUNT: count_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // snapshot the header fields with the address of each accepted request
    always_comb
    begin
        q_push       = push && !q_full;
        q_data.slave = slave_reg;
        q_data.func  = func_reg;
        q_data.addr  = register_address;
        q_data.count = count_reg;
    end

endmodule

`default_nettype wire

FILE: design/mrf_queue.sv
// Small request queue between front end and byte sequencer.
// Depends on mrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrf_queue #(
    parameter int DEPTH = 2
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    wr_en,
    input  mrf_pkg::request_t      wr_data,
    output logic                   full,
    input  wire                    rd_en,
    output logic                   rd_valid,
    output mrf_pkg::request_t      rd_data
);
    import mrf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    request_t          mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              do_wr;
    logic              do_rd;

    assign full     = (cnt_reg == FULL_CNT);
    assign rd_valid = (cnt_reg != '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/mrf_back.sv
// Back end: walks one request through its eight frame bytes and folds each
// header byte into the CRC as it leaves. Depends on mrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrf_back (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    q_valid,
    input  mrf_pkg::request_t      q_data,
    output logic                   q_pop,
    output logic                   empty,
    input  wire                    pop,
    output logic [7:0]             frame_byte,
    output logic                   last_byte
);
    import mrf_pkg::*;

    logic                 active_reg;
    logic [IDX_W-1:0]     idx_reg;
    request_t             req_reg;
    logic [15:0]          crc_reg;
    logic                 take;
    logic                 finish;
    logic                 load;

    assign empty     = !active_reg;
    assign last_byte = (idx_reg == BYTE_CRC_HI);
    assign take      = active_reg && pop;
    assign finish    = take && last_byte;
    assign load      = q_valid && (!active_reg || finish);
    assign q_pop     = load;

    always_comb
    begin
        case (idx_reg)
            BYTE_SLAVE:   frame_byte = req_reg.slave;
            BYTE_FUNC:    frame_byte = req_reg.func;
            BYTE_ADDR_HI: frame_byte = req_reg.addr[15:8];
            BYTE_ADDR_LO: frame_byte = req_reg.addr[7:0];
            BYTE_CNT_HI:  frame_byte = req_reg.count[15:8];
            BYTE_CNT_LO:  frame_byte = req_reg.count[7:0];
            BYTE_CRC_LO:  frame_byte = crc_reg[7:0];
            BYTE_CRC_HI:  frame_byte = crc_reg[15:8];
            default:      frame_byte = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= q_data;
            crc_reg <= CRC_INIT;
        end
        else if (take && (idx_reg < BYTE_CRC_LO))
        begin
            crc_reg <= crc_byte(crc_reg, frame_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else if (load)
        begin
            active_reg <= 1'b1;
            idx_reg    <= BYTE_SLAVE;
        end
        else if (finish)
        begin
            active_reg <= 1'b0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

endmodule

`default_nettype wire

FILE: design/modbus_read_request_framer.sv
// Modbus RTU read request framer top level: front end, request queue, byte sequencer.
// Depends on mrf_pkg, mrf_front, mrf_queue and mrf_back.
`timescale 1ns / 1ps
`default_nettype none

// Each request pushed in (a 16-bit starting register address) comes out as an
// eight-byte Modbus RTU read request, one byte per pop: slave address, function
// code, address high and low, count high and low, then CRC-16/Modbus low and high,
// with last_byte set on the final CRC byte. Slave address, function code and count
// come from the configuration registers (reset 1, 4, 2) as they stand when the
// request is pushed. A request occupies the byte port for its eight bytes, and the next
// queued request is loaded as the last byte is popped, so with pop held high frames
// follow back to back. When the block is idle, an accepted request is written into the
// queue and then loaded into the sequencer before its first byte is on the byte port.
// QUEUE_DEPTH requests can wait behind the one being sent, so push stays open
// while bytes are still being drained.
module modbus_read_request_framer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_write,
    input  wire [1:0]   cfg_index,
    input  wire [15:0]  cfg_data,
    input  wire         push,
    output logic        full,
    input  wire [15:0]  register_address,
    output logic        empty,
    input  wire         pop,
    output logic [7:0]  frame_byte,
    output logic        last_byte
);
    import mrf_pkg::*;

    logic      q_push;
    request_t  q_wr_data;
    logic      q_pop;
    logic      q_valid;
    request_t  q_rd_data;

    mrf_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .push             (push),
        .register_address (register_address),
        .q_full           (full),
        .q_push           (q_push),
        .q_data           (q_wr_data)
    );

    mrf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  (q_wr_data),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data)
    );

    mrf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_rd_data),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .frame_byte (frame_byte),
        .last_byte  (last_byte)
    );

endmodule

`default_nettype wire

FILE: tb/modbus_request_checker.sv
// Scoreboard for the Modbus RTU read request framer: keeps its own copy of the
// configuration, predicts every frame byte with CRC and compares what is popped.
// Depends on mrf_pkg for the configuration register indexes.
`timescale 1ns / 1ps

module modbus_request_checker
    import mrf_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_write,
    input  wire [1:0]   cfg_index,
    input  wire [15:0]  cfg_data,
    input  wire         push,
    input  wire         full,
    input  wire [15:0]  register_address,
    input  wire         empty,
    input  wire         pop,
    input  wire [7:0]   frame_byte,
    input  wire         last_byte,
    output int          errors,
    output int          bytes_due,
    output int          requests_framed,
    output int          bytes_compared
);

    localparam logic [7:0]  SLAVE_AFTER_RESET  = 8'h01;
    localparam logic [7:0]  FUNC_AFTER_RESET   = 8'h04;
    localparam logic [15:0] COUNT_AFTER_RESET  = 16'h0002;
    localparam logic [15:0] CRC_SEED           = 16'hFFFF;
    localparam logic [15:0] CRC_REFLECTED_POLY = 16'hA001;
    localparam int          FRAME_BYTES        = 8;
    localparam int          MAX_REPORTS        = 60;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_byte_t;

    logic [7:0]  slave_addr_q;
    logic [7:0]  func_code_q;
    logic [15:0] reg_count_q;
    frame_byte_t due_bytes[$];
    frame_byte_t head;

    // CRC-16/Modbus over the six header bytes, first byte in the top bits
    function automatic logic [15:0] modbus_crc(input logic [47:0] header);
        logic [15:0] acc;
        acc = CRC_SEED;
        for (int k = 0; k < 6; k++)
        begin
            acc = acc ^ {8'h00, header[47 - 8*k -: 8]};
            for (int b = 0; b < 8; b++)
            begin
                acc = acc[0] ? ((acc >> 1) ^ CRC_REFLECTED_POLY) : (acc >> 1);
            end
        end
        return acc;
    endfunction

    function automatic void queue_read_request(input logic [15:0] start_addr);
        logic [47:0] header;
        logic [15:0] crc;
        logic [63:0] frame;
        frame_byte_t fb;
        header = {slave_addr_q, func_code_q, start_addr, reg_count_q};
        crc    = modbus_crc(header);
        // CRC goes out low byte first
        frame  = {header, crc[7:0], crc[15:8]};
        for (int k = 0; k < FRAME_BYTES; k++)
        begin
            fb.value = frame[63 - 8*k -: 8];
            fb.last  = (k == FRAME_BYTES - 1);
            due_bytes.push_back(fb);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (errors < MAX_REPORTS)
        begin
            $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        end
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_q    = SLAVE_AFTER_RESET;
            func_code_q     = FUNC_AFTER_RESET;
            reg_count_q     = COUNT_AFTER_RESET;
            due_bytes.delete();
            errors          = 0;
            requests_framed = 0;
            bytes_compared  = 0;
            bytes_due      <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                bytes_compared++;
                if (due_bytes.size() == 0)
                begin
                    report_mismatch("byte with no request pending", {8'h00, frame_byte}, 16'h0000);
                end
                else
                begin
                    head = due_bytes.pop_front();
                    if (frame_byte !== head.value)
                    begin
                        report_mismatch("frame_byte", {8'h00, frame_byte}, {8'h00, head.value});
                    end
                    if (last_byte !== head.last)
                    begin
                        report_mismatch("last_byte", {15'h0000, last_byte}, {15'h0000, head.last});
                    end
                end
            end
            if (push && !full)
            begin
                queue_read_request(register_address);
                requests_framed++;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SLAVE: slave_addr_q = cfg_data[7:0];
                    CFG_FUNC:  func_code_q  = cfg_data[7:0];
                    CFG_COUNT: reg_count_q  = cfg_data;
                    default:   ;
                endcase
            end
            bytes_due <= due_bytes.size();
        end
    end

endmodule

FILE: tb/modbus_read_request_framer_tb.sv
// Top of the framer testbench: clock, reset, request and configuration stimulus,
// byte receiver with random stalls, and the verdict.
// Depends on mrf_pkg, modbus_read_request_framer and modbus_request_checker.
`timescale 1ns / 1ps

module modbus_read_request_framer_tb;
    import mrf_pkg::*;

    localparam logic [1:0] CFG_UNUSED      = 2'd3;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         HOLD_CYCLES     = 150;
    localparam int         RANDOM_PHASES   = 8;
    localparam int         ITEMS_PER_PHASE = 25;
    localparam int         SETTLE_CYCLES   = 20;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        push;
    logic        full;
    logic [15:0] register_address;
    logic        empty;
    logic        pop;
    logic [7:0]  frame_byte;
    logic        last_byte;

    int errors;
    int bytes_due;
    int requests_framed;
    int bytes_compared;
    int cfg_writes;
    int cycles;
    bit tx_idle_on;
    bit rx_idle_on;
    bit rx_hold_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    modbus_read_request_framer u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .push             (push),
        .full             (full),
        .register_address (register_address),
        .empty            (empty),
        .pop              (pop),
        .frame_byte       (frame_byte),
        .last_byte        (last_byte)
    );

    modbus_request_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .push             (push),
        .full             (full),
        .register_address (register_address),
        .empty            (empty),
        .pop              (pop),
        .frame_byte       (frame_byte),
        .last_byte        (last_byte),
        .errors           (errors),
        .bytes_due        (bytes_due),
        .requests_framed  (requests_framed),
        .bytes_compared   (bytes_compared)
    );

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("modbus_read_request_framer verification failed");
        $finish;
    end

    // byte receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 9) == 0)
                begin
                    stall_left = $urandom_range(1, 19);
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        cfg_writes++;
    endtask

    // offer one request and hold it until the block takes it
    task automatic send_request(input logic [15:0] addr);
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        push             <= 1'b1;
        register_address <= addr;
        @(posedge clk);
        while (full) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained;
        push <= 1'b0;
        @(posedge clk);
        while (bytes_due != 0) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_value;
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        push             <= 1'b0;
        register_address <= 16'h0000;
        cfg_write        <= 1'b0;
        cfg_index        <= CFG_SLAVE;
        cfg_data         <= 16'h0000;
        rst_n            <= 1'b0;
        cfg_writes  = 0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        rx_hold_req = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // registers at their reset values, address extremes and bit patterns
        send_request(16'h0000);
        send_request(16'hFFFF);
        send_request(16'h00FF);
        send_request(16'hFF00);
        send_request(16'h5555);
        send_request(16'hAAAA);
        send_request(16'h0001);
        send_request(16'h8000);
        wait_drained();

        // all registers zero; set upper data bits to check they are dropped
        write_reg(CFG_SLAVE, 16'hFF00);
        write_reg(CFG_FUNC, 16'hFF00);
        write_reg(CFG_COUNT, 16'h0000);
        send_request(16'hFFFF);
        send_request(16'h0000);
        wait_drained();

        write_reg(CFG_SLAVE, 16'h00FF);
        write_reg(CFG_FUNC, 16'h00FF);
        write_reg(CFG_COUNT, 16'hFFFF);
        send_request(16'h0000);
        send_request(16'hFFFF);
        send_request(16'h1234);
        wait_drained();

        // a write to the unused index must leave every register alone
        write_reg(CFG_UNUSED, 16'hA5A5);
        send_request(16'h4321);
        wait_drained();

        // holding-register read
        write_reg(CFG_SLAVE, 16'h0011);
        write_reg(CFG_FUNC, 16'h0003);
        write_reg(CFG_COUNT, 16'h0001);
        send_request(16'h006B);
        send_request(16'h8001);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            write_reg(CFG_SLAVE, pick_value());
            write_reg(CFG_FUNC, pick_value());
            write_reg(CFG_COUNT, pick_value());
            if (phase % 2 == 1)
            begin
                write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
            end
            // stall the receiver while requests keep coming, so the block fills up
            if (phase == 2)
            begin
                tx_idle_on  = 1'b0;
                rx_hold_req = 1'b1;
            end
            else if (phase >= RANDOM_PHASES - 2)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            else
            begin
                tx_idle_on = 1'b1;
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    send_request(pick_value());
                end
                else
                begin
                    send_request(16'($urandom_range(0, 65535)));
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Framed %0d read requests under %0d register writes, %0d bytes compared,",
                 requests_framed, cfg_writes, bytes_compared);
        $display("including a full-queue stall and runs with and without idle gaps.");
        if (errors == 0 && bytes_due == 0)
        begin
            $display("modbus_read_request_framer verification clean");
        end
        else
        begin
            $display("modbus_read_request_framer verification failed");
        end
        $finish;
    end

endmodule
